// ----- rtl/ptws_pkg.sv -----
// Package for the periodic task wakeup scheduler: sizes, codes and shared types.
// Used by every RTL file and by the channel interfaces; depends on nothing.
package ptws_pkg;

  // Table and field sizes
  localparam int MAX_SLOTS = 32;
  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
  localparam int DATA_W    = 32;
  localparam int ACT_W     = 3;
  localparam int STAT_W    = 2;
  localparam int ADDR_W    = 3;

  // Register reset values
  localparam logic [DATA_W-1:0] HORIZON_RESET = 32'd86400;
  localparam logic [DATA_W-1:0] WAIT_RESET    = 32'd60;

  // Request actions
  typedef enum logic [ACT_W-1:0] {
    ACT_TICK  = 3'd0,
    ACT_REG   = 3'd1,
    ACT_COMPL = 3'd2,
    ACT_TRIG  = 3'd3,
    ACT_QUERY = 3'd4,
    ACT_CLEAR = 3'd5
  } ptws_act_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_NOREG = 2'd2
  } ptws_stat_t;

  // Configuration register indexes
  typedef enum logic {
    REG_HORIZON = 1'b0,
    REG_WAIT    = 1'b1
  } ptws_reg_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic rd_slot;
    logic cmpl_wr;
    logic scan_init;
    logic scan_step;
    logic scan_fin;
    logic out_load;
  } ptws_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    ptws_act_t action;
    logic      slot_ok;
    logic      scan_done;
    logic      out_free;
  } ptws_sts_t;

  // One result
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] selected_slot;
    logic              task_found;
    logic              task_due;
    logic [DATA_W-1:0] seconds_to_next;
  } ptws_res_t;

  // Add that sticks at all ones on overflow
  function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b);
    logic [DATA_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DATA_W] ? {DATA_W{1'b1}} : s[DATA_W-1:0];
  endfunction

endpackage

// ----- rtl/ptws_if.sv -----
// Request and result channel interfaces of the task wakeup scheduler.
// Depends on ptws_pkg for field widths.
interface ptws_req_if import ptws_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [SLOT_W-1:0] task_slot;
  logic [DATA_W-1:0] interval;

  modport source(output valid, action, task_slot, interval, input ready);
  modport sink(input valid, action, task_slot, interval, output ready);
endinterface

interface ptws_res_if import ptws_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [SLOT_W-1:0] selected_slot;
  logic              task_found;
  logic              task_due;
  logic [DATA_W-1:0] seconds_to_next;

  modport source(output valid, status, selected_slot, task_found, task_due,
                 seconds_to_next, input ready);
  modport sink(input valid, status, selected_slot, task_found, task_due,
               seconds_to_next, output ready);
endinterface

// ----- rtl/ptws_regs.sv -----
// Configuration registers (lookahead horizon, default wait) behind an APB-style port.
// Depends on ptws_pkg.
module ptws_regs import ptws_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output logic [DATA_W-1:0] horizon,
  output logic [DATA_W-1:0] dflt_wait
);

  logic [DATA_W-1:0] horizon_r;
  logic [DATA_W-1:0] wait_r;
  ptws_reg_t         reg_idx;
  logic              wr_en;

  assign reg_idx = ptws_reg_t'(paddr[ADDR_W-1:2]);
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  // Take register writes in the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      horizon_r <= HORIZON_RESET;
      wait_r    <= WAIT_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_HORIZON: horizon_r <= pwdata;
        REG_WAIT:    wait_r    <= pwdata;
        default:     ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      REG_HORIZON: prdata = horizon_r;
      REG_WAIT:    prdata = wait_r;
      default:     prdata = '0;
    endcase
  end

  assign horizon   = horizon_r;
  assign dflt_wait = wait_r;

endmodule

// ----- rtl/ptws_dp.sv -----
// Datapath: time counter, task table memories, event flags, query scan and result registers.
// Depends on ptws_pkg; driven by ptws_ctrl through ptws_cmd_t.
module ptws_dp import ptws_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  ptws_cmd_t         cmd,
  output ptws_sts_t         sts,
  input  logic [ACT_W-1:0]  in_action,
  input  logic [SLOT_W-1:0] in_task_slot,
  input  logic [DATA_W-1:0] in_interval,
  input  logic [DATA_W-1:0] horizon,
  input  logic [DATA_W-1:0] dflt_wait,
  input  logic              out_ready,
  output logic              out_valid,
  output ptws_res_t         out_res
);

  // Captured request
  ptws_act_t         act_r;
  logic [SLOT_W-1:0] slot_r;
  logic [DATA_W-1:0] ival_r;

  // Scheduler state
  logic [DATA_W-1:0]    cur_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [MAX_SLOTS-1:0] flags_r;

  // Task table
  logic [DATA_W-1:0] due_mem [MAX_SLOTS];
  logic [DATA_W-1:0] int_mem [MAX_SLOTS];
  logic [DATA_W-1:0] due_rd_r;
  logic [DATA_W-1:0] int_rd_r;

  // Scan state
  logic [CNT_W-1:0]  rd_idx_r;
  logic              cmp_vld_r;
  logic [SLOT_W-1:0] cmp_idx_r;
  logic [DATA_W-1:0] limit_r;
  logic              have_r;
  logic              hit_r;
  logic [SLOT_W-1:0] best_r;
  logic [DATA_W-1:0] best_due_r;

  // Result and output registers
  ptws_res_t res_r;
  ptws_res_t out_res_r;
  logic      out_vld_r;

  logic              slot_ok;
  logic              full;
  logic [SLOT_W-1:0] rd_addr;
  logic [SLOT_W-1:0] wr_addr;
  logic [DATA_W-1:0] wr_due;
  logic              reg_we;
  logic              due_we;
  logic              hit_now;
  logic              closer;
  ptws_res_t         exec_res;

  assign slot_ok = {{(CNT_W-SLOT_W){1'b0}}, slot_r} < cnt_r;
  assign full    = cnt_r >= CNT_W'(MAX_SLOTS);

  // Memory addressing: one read port, one write port
  assign rd_addr = cmd.rd_slot   ? slot_r :
                   cmd.scan_init ? '0     : rd_idx_r[SLOT_W-1:0];
  assign wr_addr = cmd.cmpl_wr ? slot_r : cnt_r[SLOT_W-1:0];
  assign wr_due  = sat_add(cur_r, cmd.cmpl_wr ? int_rd_r : ival_r);
  assign reg_we  = cmd.exec && (act_r == ACT_REG) && !full;
  assign due_we  = reg_we || cmd.cmpl_wr;

  // Compare stage of the scan
  assign hit_now = cmp_vld_r && (flags_r[cmp_idx_r] || (due_rd_r <= cur_r));
  assign closer  = cmp_vld_r && !hit_now && (due_rd_r < limit_r);

  // Result of the actions completed by the exec command
  always_comb begin
    exec_res = '0;
    case (act_r)
      ACT_REG: begin
        if (full) begin
          exec_res.status = ST_FULL;
        end else begin
          exec_res.selected_slot = cnt_r[SLOT_W-1:0];
        end
      end
      ACT_COMPL,
      ACT_TRIG: exec_res.status = slot_ok ? ST_OK : ST_NOREG;
      default:  exec_res.status = ST_OK;
    endcase
  end

  // Table memories with registered read
  always_ff @(posedge clk) begin
    if (due_we) begin
      due_mem[wr_addr] <= wr_due;
    end
    if (reg_we) begin
      int_mem[wr_addr] <= ival_r;
    end
    due_rd_r <= due_mem[rd_addr];
    int_rd_r <= int_mem[rd_addr];
  end

  // Time, count, flags and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r     <= '0;
      cnt_r     <= '0;
      flags_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (cmd.exec) begin
        case (act_r)
          ACT_TICK: cur_r <= sat_add(cur_r, DATA_W'(1));
          ACT_REG: begin
            if (!full) begin
              cnt_r                       <= cnt_r + CNT_W'(1);
              flags_r[cnt_r[SLOT_W-1:0]] <= 1'b0;
            end
          end
          ACT_TRIG: begin
            if (slot_ok) begin
              flags_r[slot_r] <= 1'b1;
            end
          end
          ACT_CLEAR: begin
            cnt_r   <= '0;
            flags_r <= '0;
          end
          default: ;
        endcase
      end
      if (cmd.cmpl_wr) begin
        flags_r[slot_r] <= 1'b0;
      end
      if (cmd.out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Request capture, scan and result payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r  <= ptws_act_t'(in_action);
      slot_r <= in_task_slot;
      ival_r <= in_interval;
    end
    if (cmd.exec) begin
      res_r <= exec_res;
    end
    if (cmd.cmpl_wr) begin
      res_r <= '0;
    end
    // start the scan at slot zero
    if (cmd.scan_init) begin
      limit_r    <= sat_add(cur_r, horizon);
      rd_idx_r   <= CNT_W'(1);
      cmp_vld_r  <= (cnt_r != '0);
      cmp_idx_r  <= '0;
      have_r     <= 1'b0;
      hit_r      <= 1'b0;
      best_r     <= '0;
      best_due_r <= '0;
    end
    // compare one slot, fetch the next
    if (cmd.scan_step) begin
      if (hit_now || closer) begin
        have_r     <= 1'b1;
        best_r     <= cmp_idx_r;
        best_due_r <= due_rd_r;
      end
      if (closer) begin
        limit_r <= due_rd_r;
      end
      if (hit_now) begin
        hit_r <= 1'b1;
      end
      cmp_vld_r <= (rd_idx_r < cnt_r) && !hit_now;
      cmp_idx_r <= rd_idx_r[SLOT_W-1:0];
      rd_idx_r  <= rd_idx_r + CNT_W'(1);
    end
    // build the query answer
    if (cmd.scan_fin) begin
      res_r.status        <= ST_OK;
      res_r.selected_slot <= have_r ? best_r : '0;
      res_r.task_found    <= have_r;
      res_r.task_due      <= hit_r;
      if (!have_r) begin
        res_r.seconds_to_next <= dflt_wait;
      end else if (best_due_r > cur_r) begin
        res_r.seconds_to_next <= best_due_r - cur_r;
      end else begin
        res_r.seconds_to_next <= '0;
      end
    end
    if (cmd.out_load) begin
      out_res_r <= res_r;
    end
  end

  assign sts.action    = act_r;
  assign sts.slot_ok   = slot_ok;
  assign sts.scan_done = !cmp_vld_r || hit_now;
  assign sts.out_free  = !out_vld_r || out_ready;

  assign out_valid = out_vld_r;
  assign out_res   = out_res_r;

  // Table fill never passes its size
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_SLOTS))
    else $error("task count beyond table size");

  // Scan compares only registered slots
  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan_step && cmp_vld_r) |-> ({{(CNT_W-SLOT_W){1'b0}}, cmp_idx_r} < cnt_r))
    else $error("scan compared an unregistered slot");

  // A due hit is always reported as found and due
  a_hit_found: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan_fin && hit_r) |=> (res_r.task_found && res_r.task_due))
    else $error("due hit lost in query result");

  // Registering into a free slot grows the table by one
  a_reg_grow: assert property (@(posedge clk) disable iff (!rst_n)
    reg_we |=> (cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("register did not advance task count");

endmodule

// ----- rtl/ptws_ctrl.sv -----
// Controller state machine: sequences capture, execution, query scan and result hand-off.
// Depends on ptws_pkg; commands ptws_dp through ptws_cmd_t.
module ptws_ctrl import ptws_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  ptws_sts_t sts,
  output ptws_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DEC  = 6'b000010,
    S_CMPL = 6'b000100,
    S_SCAN = 6'b001000,
    S_FIN  = 6'b010000,
    S_DONE = 6'b100000
  } ptws_state_t;

  ptws_state_t state_r;
  ptws_state_t state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        case (sts.action)
          ACT_QUERY: begin
            cmd.scan_init = 1'b1;
            state_nxt     = S_SCAN;
          end
          ACT_COMPL: begin
            if (sts.slot_ok) begin
              cmd.rd_slot = 1'b1;
              state_nxt   = S_CMPL;
            end else begin
              cmd.exec  = 1'b1;
              state_nxt = S_DONE;
            end
          end
          default: begin
            cmd.exec  = 1'b1;
            state_nxt = S_DONE;
          end
        endcase
      end
      S_CMPL: begin
        cmd.cmpl_wr = 1'b1;
        state_nxt   = S_DONE;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.scan_fin = 1'b1;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // At most one datapath operation per cycle
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.exec, cmd.rd_slot, cmd.cmpl_wr, cmd.scan_init,
              cmd.scan_step, cmd.scan_fin, cmd.out_load}))
    else $error("conflicting datapath commands");

  // An accepted request is decoded next
  a_accept_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_DEC))
    else $error("accepted request not decoded");

  // A handed-off result frees the block
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> in_ready)
    else $error("block not idle after result hand-off");

endmodule

// ----- rtl/periodic_task_wakeup_scheduler_top.sv -----
// Top level of the periodic task wakeup scheduler: channels, APB port and sub-blocks.
// Depends on ptws_pkg, ptws_if, ptws_regs, ptws_dp and ptws_ctrl.

// The block keeps up to 32 periodic tasks and a seconds counter, and answers
// each request with exactly one result. It handles one request at a time:
// tick, register, trigger and clear execute from the decode state, complete
// of a registered slot first reads the interval memory and then rewrites the
// due time, and query walks the registered tasks with a single due-time
// comparator, one slot per cycle behind the registered read of the due-time
// memory; a flagged or already due task ends the walk early. A finished
// result sits in an output register, so the next request is taken while
// it waits. The two configuration registers sit at byte addresses 0
// (lookahead horizon) and 4 (default wait) and may be written only while
// the block is idle.
module periodic_task_wakeup_scheduler_top import ptws_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  ptws_req_if.sink          in_ch,
  ptws_res_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [DATA_W-1:0] horizon;
  logic [DATA_W-1:0] dflt_wait;
  ptws_cmd_t         cmd;
  ptws_sts_t         sts;
  ptws_res_t         res;
  logic              in_ready;
  logic              out_valid;

  // Configuration registers
  ptws_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .horizon   (horizon),
    .dflt_wait (dflt_wait)
  );

  // Sequencer
  ptws_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Table, time and scan
  ptws_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_action    (in_ch.action),
    .in_task_slot (in_ch.task_slot),
    .in_interval  (in_ch.interval),
    .horizon      (horizon),
    .dflt_wait    (dflt_wait),
    .out_ready    (out_ch.ready),
    .out_valid    (out_valid),
    .out_res      (res)
  );

  // Drive the channels
  assign in_ch.ready            = in_ready;
  assign out_ch.valid           = out_valid;
  assign out_ch.status          = res.status;
  assign out_ch.selected_slot   = res.selected_slot;
  assign out_ch.task_found      = res.task_found;
  assign out_ch.task_due        = res.task_due;
  assign out_ch.seconds_to_next = res.seconds_to_next;

endmodule
